/* hw/rtl/emfp_pkg.sv */
// Shared types, constants and codes of the energy meter frame parser.
package emfp_pkg;

   // Frame layout
   localparam logic [7:0] FRAME_HEADER  = 8'h55;
   localparam logic [7:0] CHECKSUM_SEED = 8'h58;
   localparam int         POS_WIDTH     = 5;
   localparam logic [POS_WIDTH-1:0] LAST_POSITION = 5'd22;

   // Byte positions of the captured fields
   localparam logic [POS_WIDTH-1:0] POS_HEADER    = 5'd0;
   localparam logic [POS_WIDTH-1:0] POS_CURRENT_0 = 5'd1;
   localparam logic [POS_WIDTH-1:0] POS_CURRENT_1 = 5'd2;
   localparam logic [POS_WIDTH-1:0] POS_CURRENT_2 = 5'd3;
   localparam logic [POS_WIDTH-1:0] POS_VOLTAGE_0 = 5'd4;
   localparam logic [POS_WIDTH-1:0] POS_VOLTAGE_1 = 5'd5;
   localparam logic [POS_WIDTH-1:0] POS_VOLTAGE_2 = 5'd6;
   localparam logic [POS_WIDTH-1:0] POS_POWER_0   = 5'd10;
   localparam logic [POS_WIDTH-1:0] POS_POWER_1   = 5'd11;
   localparam logic [POS_WIDTH-1:0] POS_POWER_2   = 5'd12;
   localparam logic [POS_WIDTH-1:0] POS_PULSE_0   = 5'd13;
   localparam logic [POS_WIDTH-1:0] POS_PULSE_1   = 5'd14;
   localparam logic [POS_WIDTH-1:0] POS_PULSE_2   = 5'd15;
   localparam logic [POS_WIDTH-1:0] POS_STATUS    = 5'd19;

   // Error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_HEADER   = 2'd1;
   localparam logic [1:0] ERR_CHECKSUM = 2'd2;

   // Gain format
   localparam int GAIN_WIDTH         = 32;
   localparam int GAIN_FRACTION_BITS = 24;
   localparam int WORD_WIDTH         = 24;
   localparam int SCALED_WIDTH       = 32;
   localparam int SPROD_WIDTH        = WORD_WIDTH + GAIN_WIDTH + 1;
   localparam int UPROD_WIDTH        = WORD_WIDTH + GAIN_WIDTH;

   // Register map
   localparam int ADDR_WIDTH = 4;
   localparam logic [1:0] REG_VOLTAGE_GAIN = 2'd0;
   localparam logic [1:0] REG_CURRENT_GAIN = 2'd1;
   localparam logic [1:0] REG_POWER_GAIN   = 2'd2;
   localparam logic [1:0] REG_ENERGY_GAIN  = 2'd3;

   // One parsed frame, handed from the front to the back
   typedef struct packed {
      logic [1:0]                   error_code;
      logic signed [WORD_WIDTH-1:0] raw_current;
      logic signed [WORD_WIDTH-1:0] raw_voltage;
      logic signed [WORD_WIDTH-1:0] raw_power;
      logic [WORD_WIDTH-1:0]        pulse_count;
      logic [7:0]                   status_byte;
   } frame_type;

   // Gain register set
   typedef struct packed {
      logic [GAIN_WIDTH-1:0] voltage_gain;
      logic [GAIN_WIDTH-1:0] current_gain;
      logic [GAIN_WIDTH-1:0] power_gain;
      logic [GAIN_WIDTH-1:0] energy_gain;
   } gains_type;

   // Scaled results of one frame
   typedef struct packed {
      logic signed [SCALED_WIDTH-1:0] current_scaled;
      logic signed [SCALED_WIDTH-1:0] voltage_scaled;
      logic signed [SCALED_WIDTH-1:0] power_scaled;
      logic [SCALED_WIDTH-1:0]        energy_scaled;
   } scaled_type;

endpackage

/* hw/rtl/emfp_front.sv */
// Byte front end: tracks frame position, checksum and captured words.
module emfp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                beat,
   input  logic [7:0]          rx_byte,
   input  logic                frame_start,
   output logic                push,
   output emfp_pkg::frame_type frame
);
   import emfp_pkg::*;

   logic [POS_WIDTH-1:0]  pos_ff, pos_in;
   logic                  active_ff, active_in;
   logic [7:0]            sum_ff, sum_in;
   logic                  header_good_ff, header_good_in;
   logic [WORD_WIDTH-1:0] current_ff, current_in;
   logic [WORD_WIDTH-1:0] voltage_ff, voltage_in;
   logic [WORD_WIDTH-1:0] power_ff, power_in;
   logic [WORD_WIDTH-1:0] pulse_ff, pulse_in;
   logic [7:0]            status_ff, status_in;

   logic                 eff_active;
   logic [POS_WIDTH-1:0] eff_pos;
   logic [7:0]           eff_sum;

   // Restart takes precedence over any partial frame
   assign eff_active = frame_start | active_ff;
   assign eff_pos    = frame_start ? POS_HEADER : pos_ff;
   assign eff_sum    = frame_start ? CHECKSUM_SEED : sum_ff;

   // Capture bytes and advance the position
   always_comb begin
      pos_in         = pos_ff;
      active_in      = active_ff;
      sum_in         = sum_ff;
      header_good_in = header_good_ff;
      current_in     = current_ff;
      voltage_in     = voltage_ff;
      power_in       = power_ff;
      pulse_in       = pulse_ff;
      status_in      = status_ff;
      push           = 1'b0;
      if (beat && eff_active) begin
         unique case (eff_pos)
            POS_HEADER:    header_good_in = (rx_byte == FRAME_HEADER);
            POS_CURRENT_0: current_in[7:0]   = rx_byte;
            POS_CURRENT_1: current_in[15:8]  = rx_byte;
            POS_CURRENT_2: current_in[23:16] = rx_byte;
            POS_VOLTAGE_0: voltage_in[7:0]   = rx_byte;
            POS_VOLTAGE_1: voltage_in[15:8]  = rx_byte;
            POS_VOLTAGE_2: voltage_in[23:16] = rx_byte;
            POS_POWER_0:   power_in[7:0]     = rx_byte;
            POS_POWER_1:   power_in[15:8]    = rx_byte;
            POS_POWER_2:   power_in[23:16]   = rx_byte;
            POS_PULSE_0:   pulse_in[7:0]     = rx_byte;
            POS_PULSE_1:   pulse_in[15:8]    = rx_byte;
            POS_PULSE_2:   pulse_in[23:16]   = rx_byte;
            POS_STATUS:    status_in         = rx_byte;
            default: ;
         endcase
         if (eff_pos < LAST_POSITION) begin
            sum_in    = eff_sum + rx_byte;
            pos_in    = eff_pos + 1'b1;
            active_in = 1'b1;
         end else begin
            push      = 1'b1;
            sum_in    = CHECKSUM_SEED;
            pos_in    = POS_HEADER;
            active_in = 1'b0;
         end
      end
   end

   // Build the frame record on the checksum byte
   always_comb begin
      frame.raw_current = current_ff;
      frame.raw_voltage = voltage_ff;
      frame.raw_power   = power_ff;
      frame.pulse_count = pulse_ff;
      frame.status_byte = status_ff;
      if (!header_good_ff) begin
         frame.error_code = ERR_HEADER;
      end else if (~eff_sum != rx_byte) begin
         frame.error_code = ERR_CHECKSUM;
      end else begin
         frame.error_code = ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_HEADER;
         active_ff <= 1'b0;
         sum_ff    <= CHECKSUM_SEED;
      end else begin
         pos_ff    <= pos_in;
         active_ff <= active_in;
         sum_ff    <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      header_good_ff <= header_good_in;
      current_ff     <= current_in;
      voltage_ff     <= voltage_in;
      power_ff       <= power_in;
      pulse_ff       <= pulse_in;
      status_ff      <= status_in;
   end

endmodule

/* hw/rtl/emfp_queue.sv */
// Two-entry queue of parsed frames between front and back.
module emfp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  emfp_pkg::frame_type push_frame,
   input  logic                pop,
   output logic                not_empty,
   output logic                full,
   output emfp_pkg::frame_type pop_frame
);
   import emfp_pkg::*;

   frame_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign not_empty = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign pop_frame = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed frame
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

/* hw/rtl/emfp_back.sv */
// Scaling back end: gain multiply stage, then shift and saturate into the result register.
module emfp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  emfp_pkg::gains_type  gains,
   input  logic                 q_not_empty,
   input  emfp_pkg::frame_type  q_frame,
   output logic                 q_pop,
   output logic                 out_valid,
   input  logic                 out_stall,
   output emfp_pkg::frame_type  out_frame,
   output emfp_pkg::scaled_type out_scaled
);
   import emfp_pkg::*;

   localparam logic signed [SPROD_WIDTH-1:0] SMAX = SPROD_WIDTH'(64'sh7FFF_FFFF);
   localparam logic signed [SPROD_WIDTH-1:0] SMIN = -SPROD_WIDTH'(64'sh8000_0000);

   logic                          s1_valid_ff, s1_valid_in;
   frame_type                     s1_frame_ff;
   logic signed [SPROD_WIDTH-1:0] cur_prod_ff, cur_prod_in;
   logic signed [SPROD_WIDTH-1:0] vol_prod_ff, vol_prod_in;
   logic signed [SPROD_WIDTH-1:0] pow_prod_ff, pow_prod_in;
   logic [UPROD_WIDTH-1:0]        nrg_prod_ff, nrg_prod_in;

   logic       out_valid_ff, out_valid_in;
   frame_type  out_frame_ff;
   scaled_type out_scaled_ff, out_scaled_in;

   logic out_en, s1_en;

   // Shift a signed product and clamp to 32 bits
   function automatic logic signed [SCALED_WIDTH-1:0] sat_signed(
      input logic signed [SPROD_WIDTH-1:0] prod);
      logic signed [SPROD_WIDTH-1:0] sh;
      sh = prod >>> GAIN_FRACTION_BITS;
      if (sh > SMAX) begin
         sat_signed = SMAX[SCALED_WIDTH-1:0];
      end else if (sh < SMIN) begin
         sat_signed = SMIN[SCALED_WIDTH-1:0];
      end else begin
         sat_signed = sh[SCALED_WIDTH-1:0];
      end
   endfunction

   // Shift an unsigned product and clamp to 32 bits
   function automatic logic [SCALED_WIDTH-1:0] sat_unsigned(
      input logic [UPROD_WIDTH-1:0] prod);
      logic [UPROD_WIDTH-1:0] sh;
      sh = prod >> GAIN_FRACTION_BITS;
      if (|sh[UPROD_WIDTH-1:SCALED_WIDTH]) begin
         sat_unsigned = '1;
      end else begin
         sat_unsigned = sh[SCALED_WIDTH-1:0];
      end
   endfunction

   // Stage enables: each stage moves when the one after it has room
   assign out_en = !out_valid_ff || !out_stall;
   assign s1_en  = !s1_valid_ff || out_en;
   assign q_pop  = q_not_empty && s1_en;

   // Multiply stage
   always_comb begin
      s1_valid_in = s1_en ? q_not_empty : s1_valid_ff;
      cur_prod_in = q_frame.raw_current * $signed({1'b0, gains.current_gain});
      vol_prod_in = q_frame.raw_voltage * $signed({1'b0, gains.voltage_gain});
      pow_prod_in = q_frame.raw_power * $signed({1'b0, gains.power_gain});
      nrg_prod_in = q_frame.pulse_count * gains.energy_gain;
   end

   // Shift and saturate stage
   always_comb begin
      out_valid_in                 = out_en ? s1_valid_ff : out_valid_ff;
      out_scaled_in.current_scaled = sat_signed(cur_prod_ff);
      out_scaled_in.voltage_scaled = sat_signed(vol_prod_ff);
      out_scaled_in.power_scaled   = sat_signed(pow_prod_ff);
      out_scaled_in.energy_scaled  = sat_unsigned(nrg_prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold payload while the next stage is full
   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_frame_ff <= q_frame;
         cur_prod_ff <= cur_prod_in;
         vol_prod_ff <= vol_prod_in;
         pow_prod_ff <= pow_prod_in;
         nrg_prod_ff <= nrg_prod_in;
      end
      if (out_en) begin
         out_frame_ff  <= s1_frame_ff;
         out_scaled_ff <= out_scaled_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_frame  = out_frame_ff;
   assign out_scaled = out_scaled_ff;

endmodule

/* hw/rtl/energy_meter_frame_parser_unit.sv */
// Energy meter response frame parser: register file and front/queue/back assembly.
// Accepts one frame byte per cycle while not stalled and gives one result per 23-byte
// frame, registered in turn in the queue, multiply stage and saturate/output stage.
// A byte is refused only while the two-entry frame queue is full, so with the result side
// flowing the input never stalls; one 24x32 multiplier per value sets the back-end stage.
// Gain registers sit at byte addresses 0, 4, 8 and 12 (voltage, current, power, energy),
// Q8.24, reset to 1.0; write them only while no frame result is pending.
module energy_meter_frame_parser_unit (
   input  logic                                      clock,
   input  logic                                      reset,
   // Byte input
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [7:0]                                req_rx_byte,
   input  logic                                      req_frame_start,
   // Frame result
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [1:0]                                rsp_error_code,
   output logic signed [emfp_pkg::WORD_WIDTH-1:0]    rsp_raw_current,
   output logic signed [emfp_pkg::WORD_WIDTH-1:0]    rsp_raw_voltage,
   output logic signed [emfp_pkg::WORD_WIDTH-1:0]    rsp_raw_power,
   output logic [emfp_pkg::WORD_WIDTH-1:0]           rsp_pulse_count,
   output logic [7:0]                                rsp_status_byte,
   output logic signed [emfp_pkg::SCALED_WIDTH-1:0]  rsp_current_scaled,
   output logic signed [emfp_pkg::SCALED_WIDTH-1:0]  rsp_voltage_scaled,
   output logic signed [emfp_pkg::SCALED_WIDTH-1:0]  rsp_power_scaled,
   output logic [emfp_pkg::SCALED_WIDTH-1:0]         rsp_energy_scaled,
   // Register port
   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [emfp_pkg::ADDR_WIDTH-1:0]           csr_paddr,
   input  logic [31:0]                               csr_pwdata,
   output logic [31:0]                               csr_prdata,
   output logic                                      csr_pready
);
   import emfp_pkg::*;

   localparam logic [GAIN_WIDTH-1:0] GAIN_ONE = GAIN_WIDTH'(64'd1 << GAIN_FRACTION_BITS);

   gains_type  gains_ff, gains_in;
   logic       csr_write;
   logic [1:0] reg_index;

   logic       beat;
   logic       push;
   frame_type  push_frame;
   logic       q_pop, q_not_empty, q_full;
   frame_type  q_frame;
   frame_type  out_frame;
   scaled_type out_scaled;

   // Register writes
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[3:2];

   always_comb begin
      gains_in = gains_ff;
      if (csr_write) begin
         unique case (reg_index)
            REG_VOLTAGE_GAIN: gains_in.voltage_gain = csr_pwdata;
            REG_CURRENT_GAIN: gains_in.current_gain = csr_pwdata;
            REG_POWER_GAIN:   gains_in.power_gain   = csr_pwdata;
            REG_ENERGY_GAIN:  gains_in.energy_gain  = csr_pwdata;
            default: ;
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (reg_index)
         REG_VOLTAGE_GAIN: csr_prdata = gains_ff.voltage_gain;
         REG_CURRENT_GAIN: csr_prdata = gains_ff.current_gain;
         REG_POWER_GAIN:   csr_prdata = gains_ff.power_gain;
         REG_ENERGY_GAIN:  csr_prdata = gains_ff.energy_gain;
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.voltage_gain <= GAIN_ONE;
         gains_ff.current_gain <= GAIN_ONE;
         gains_ff.power_gain   <= GAIN_ONE;
         gains_ff.energy_gain  <= GAIN_ONE;
      end else begin
         gains_ff <= gains_in;
      end
   end

   // Refuse bytes only while the queue is full
   assign req_stall = q_full;
   assign beat      = req_valid && !q_full;

   emfp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .beat        (beat),
      .rx_byte     (req_rx_byte),
      .frame_start (req_frame_start),
      .push        (push),
      .frame       (push_frame)
   );

   emfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .full       (q_full),
      .pop_frame  (q_frame)
   );

   emfp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .gains       (gains_ff),
      .q_not_empty (q_not_empty),
      .q_frame     (q_frame),
      .q_pop       (q_pop),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_frame   (out_frame),
      .out_scaled  (out_scaled)
   );

   // Result fields
   assign rsp_error_code     = out_frame.error_code;
   assign rsp_raw_current    = out_frame.raw_current;
   assign rsp_raw_voltage    = out_frame.raw_voltage;
   assign rsp_raw_power      = out_frame.raw_power;
   assign rsp_pulse_count    = out_frame.pulse_count;
   assign rsp_status_byte    = out_frame.status_byte;
   assign rsp_current_scaled = out_scaled.current_scaled;
   assign rsp_voltage_scaled = out_scaled.voltage_scaled;
   assign rsp_power_scaled   = out_scaled.power_scaled;
   assign rsp_energy_scaled  = out_scaled.energy_scaled;

endmodule

/* tb/sv/tb_energy_meter_frame_parser_unit.sv */
// Self-checking testbench for the energy meter response frame parser.
module tb_energy_meter_frame_parser_unit;
   import emfp_pkg::*;

   localparam int         DRAIN_CYCLES   = 8;
   localparam int         WATCHDOG_LIMIT = 4000;
   localparam int         REPORT_LIMIT   = 10;
   localparam int         FRAME_BYTES    = 23;
   localparam logic [31:0] GAIN_ONE      = 32'h0100_0000;
   localparam longint     SCALED_MAX     = 64'sd2147483647;
   localparam longint     SCALED_MIN     = -64'sd2147483648;
   localparam longint     ENERGY_MAX     = 64'sh0_FFFF_FFFF;

   // One frame result as the block presents it
   typedef struct packed {
      logic [1:0]                     error_code;
      logic signed [WORD_WIDTH-1:0]   raw_current;
      logic signed [WORD_WIDTH-1:0]   raw_voltage;
      logic signed [WORD_WIDTH-1:0]   raw_power;
      logic [WORD_WIDTH-1:0]          pulse_count;
      logic [7:0]                     status_byte;
      logic signed [SCALED_WIDTH-1:0] current_scaled;
      logic signed [SCALED_WIDTH-1:0] voltage_scaled;
      logic signed [SCALED_WIDTH-1:0] power_scaled;
      logic [SCALED_WIDTH-1:0]        energy_scaled;
   } reading_type;

   typedef logic [0:FRAME_BYTES-1][7:0] frame_image_type;

   // Directed frame: header, uniform body byte, optional stray and restart lead-in
   typedef struct packed {
      logic [7:0]  hdr;
      logic [7:0]  fill;
      bit          bad_sum;
      logic [4:0]  strays;
      logic [4:0]  partial;
      bit          typed;
      reading_type want;
   } frame_case_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid       = 1'b0;
   logic                    req_stall;
   logic [7:0]              req_rx_byte     = '0;
   logic                    req_frame_start = 1'b0;

   logic                    rsp_valid;
   logic                    rsp_stall       = 1'b0;
   logic [1:0]              rsp_error_code;
   logic signed [WORD_WIDTH-1:0]   rsp_raw_current;
   logic signed [WORD_WIDTH-1:0]   rsp_raw_voltage;
   logic signed [WORD_WIDTH-1:0]   rsp_raw_power;
   logic [WORD_WIDTH-1:0]          rsp_pulse_count;
   logic [7:0]                     rsp_status_byte;
   logic signed [SCALED_WIDTH-1:0] rsp_current_scaled;
   logic signed [SCALED_WIDTH-1:0] rsp_voltage_scaled;
   logic signed [SCALED_WIDTH-1:0] rsp_power_scaled;
   logic [SCALED_WIDTH-1:0]        rsp_energy_scaled;

   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [ADDR_WIDTH-1:0]   csr_paddr   = '0;
   logic [31:0]             csr_pwdata  = '0;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   // Frame tracker state and gain copy
   logic [31:0]            gain_regs [4];
   bit                     frm_active;
   logic [POS_WIDTH-1:0]   frm_pos;
   logic [7:0]             frm_sum;
   bit                     hdr_ok;
   logic [WORD_WIDTH-1:0]  cur_word;
   logic [WORD_WIDTH-1:0]  volt_word;
   logic [WORD_WIDTH-1:0]  pwr_word;
   logic [WORD_WIDTH-1:0]  pulse_word;
   logic [7:0]             status_keep;

   reading_type pending_readings [$];
   int          mismatch_count = 0;
   int          idle_cycles    = 0;
   bit          gapless        = 1'b0;

   frame_case_type directed_cases [7] = '{
      '{8'h55, 8'h00, 1'b0, 5'd0, 5'd0, 1'b1, '{error_code: ERR_NONE, default: '0}},
      '{8'h55, 8'hFF, 1'b0, 5'd0, 5'd0, 1'b1,
        '{ERR_NONE, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'hFF,
          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h00FF_FFFF}},
      '{8'h00, 8'h00, 1'b0, 5'd0, 5'd0, 1'b1, '{error_code: ERR_HEADER, default: '0}},
      '{8'h55, 8'h00, 1'b1, 5'd0, 5'd0, 1'b1, '{error_code: ERR_CHECKSUM, default: '0}},
      '{8'hAA, 8'h80, 1'b1, 5'd0, 5'd0, 1'b1,
        '{ERR_HEADER, 24'h808080, 24'h808080, 24'h808080, 24'h808080, 8'h80,
          32'hFF80_8080, 32'hFF80_8080, 32'hFF80_8080, 32'h0080_8080}},
      '{8'h55, 8'h7F, 1'b0, 5'd3, 5'd9, 1'b0, '0},
      '{8'h55, 8'h01, 1'b0, 5'd0, 5'd22, 1'b0, '0}
   };

   energy_meter_frame_parser_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .req_frame_start    (req_frame_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_error_code     (rsp_error_code),
      .rsp_raw_current    (rsp_raw_current),
      .rsp_raw_voltage    (rsp_raw_voltage),
      .rsp_raw_power      (rsp_raw_power),
      .rsp_pulse_count    (rsp_pulse_count),
      .rsp_status_byte    (rsp_status_byte),
      .rsp_current_scaled (rsp_current_scaled),
      .rsp_voltage_scaled (rsp_voltage_scaled),
      .rsp_power_scaled   (rsp_power_scaled),
      .rsp_energy_scaled  (rsp_energy_scaled),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Signed word times Q8.24 gain, floored and clamped to 32 bits
   function automatic logic [31:0] gain_scale_signed(logic [WORD_WIDTH-1:0] word,
                                                     logic [31:0] gain);
      longint prod;
      prod = longint'($signed(word)) * longint'(gain);
      prod = prod >>> GAIN_FRACTION_BITS;
      if (prod > SCALED_MAX) prod = SCALED_MAX;
      if (prod < SCALED_MIN) prod = SCALED_MIN;
      return prod[31:0];
   endfunction

   function automatic logic [31:0] gain_scale_pulse(logic [WORD_WIDTH-1:0] word,
                                                    logic [31:0] gain);
      longint prod;
      prod = longint'(word) * longint'(gain);
      prod = prod >> GAIN_FRACTION_BITS;
      if (prod > ENERGY_MAX) prod = ENERGY_MAX;
      return prod[31:0];
   endfunction

   function automatic void reset_tracker();
      foreach (gain_regs[i]) gain_regs[i] = GAIN_ONE;
      frm_active  = 1'b0;
      frm_pos     = POS_HEADER;
      frm_sum     = CHECKSUM_SEED;
      hdr_ok      = 1'b0;
      cur_word    = '0;
      volt_word   = '0;
      pwr_word    = '0;
      pulse_word  = '0;
      status_keep = '0;
   endfunction

   // Track one accepted byte; on the checksum byte build the frame result
   function automatic void track_frame_byte(input logic [7:0] b, input logic s,
                                            output bit produced, output reading_type r);
      int         at;
      logic [7:0] sum_byte;
      produced = 1'b0;
      r = '0;
      if (s) begin
         frm_active = 1'b1;
         frm_pos    = POS_HEADER;
         frm_sum    = CHECKSUM_SEED;
      end
      if (!frm_active) return;
      at = int'(frm_pos);
      if (frm_pos == POS_HEADER) begin
         hdr_ok = (b == FRAME_HEADER);
      end else if (frm_pos <= POS_CURRENT_2) begin
         cur_word[8*(at - int'(POS_CURRENT_0)) +: 8] = b;
      end else if (frm_pos <= POS_VOLTAGE_2) begin
         volt_word[8*(at - int'(POS_VOLTAGE_0)) +: 8] = b;
      end else if (frm_pos >= POS_POWER_0 && frm_pos <= POS_POWER_2) begin
         pwr_word[8*(at - int'(POS_POWER_0)) +: 8] = b;
      end else if (frm_pos >= POS_PULSE_0 && frm_pos <= POS_PULSE_2) begin
         pulse_word[8*(at - int'(POS_PULSE_0)) +: 8] = b;
      end else if (frm_pos == POS_STATUS) begin
         status_keep = b;
      end
      if (frm_pos != LAST_POSITION) begin
         frm_sum = frm_sum + b;
         frm_pos = frm_pos + 1'b1;
         return;
      end
      // Checksum byte: header error wins over checksum error
      sum_byte = ~frm_sum;
      if (!hdr_ok) r.error_code = ERR_HEADER;
      else if (sum_byte != b) r.error_code = ERR_CHECKSUM;
      else r.error_code = ERR_NONE;
      r.raw_current    = cur_word;
      r.raw_voltage    = volt_word;
      r.raw_power      = pwr_word;
      r.pulse_count    = pulse_word;
      r.status_byte    = status_keep;
      r.current_scaled = gain_scale_signed(cur_word, gain_regs[REG_CURRENT_GAIN]);
      r.voltage_scaled = gain_scale_signed(volt_word, gain_regs[REG_VOLTAGE_GAIN]);
      r.power_scaled   = gain_scale_signed(pwr_word, gain_regs[REG_POWER_GAIN]);
      r.energy_scaled  = gain_scale_pulse(pulse_word, gain_regs[REG_ENERGY_GAIN]);
      frm_active = 1'b0;
      frm_pos    = POS_HEADER;
      frm_sum    = CHECKSUM_SEED;
      produced   = 1'b1;
   endfunction

   function automatic void check_field(string what, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch %s: expected %h, got %h", what, want, seen);
      end
   endfunction

   function automatic void compare_reading(reading_type want, reading_type seen);
      check_field("error_code", want.error_code, seen.error_code);
      check_field("raw_current", want.raw_current, seen.raw_current);
      check_field("raw_voltage", want.raw_voltage, seen.raw_voltage);
      check_field("raw_power", want.raw_power, seen.raw_power);
      check_field("pulse_count", want.pulse_count, seen.pulse_count);
      check_field("status_byte", want.status_byte, seen.status_byte);
      check_field("current_scaled", want.current_scaled, seen.current_scaled);
      check_field("voltage_scaled", want.voltage_scaled, seen.voltage_scaled);
      check_field("power_scaled", want.power_scaled, seen.power_scaled);
      check_field("energy_scaled", want.energy_scaled, seen.energy_scaled);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Bias words toward the signed and unsigned extremes
   function automatic logic [WORD_WIDTH-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 24'h000000;
         1: return 24'h7FFFFF;
         2: return 24'h800000;
         3: return 24'hFFFFFF;
         default: return WORD_WIDTH'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] frame_check_byte(frame_image_type f);
      logic [7:0] sum;
      sum = CHECKSUM_SEED;
      for (int i = 0; i < FRAME_BYTES - 1; i++) sum = sum + f[i];
      return ~sum;
   endfunction

   // Drive one byte beat, hold it until accepted, then predict its result
   task automatic send_byte(input logic [7:0] b, input logic s, input bit typed,
                            input reading_type want);
      int          gap;
      bit          produced;
      reading_type got;
      gap = gapless ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_rx_byte     <= b;
      req_frame_start <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_frame_byte(b, s, produced, got);
      if (produced) pending_readings.push_back(typed ? want : got);
   endtask

   task automatic csr_access(input bit is_write, input logic [1:0] idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Drain all results, let the pipeline settle, then load and read back the gains
   task automatic program_gains(input logic [31:0] v, input logic [31:0] c,
                                input logic [31:0] p, input logic [31:0] e);
      logic [31:0] values [4];
      logic [31:0] back;
      values[REG_VOLTAGE_GAIN] = v;
      values[REG_CURRENT_GAIN] = c;
      values[REG_POWER_GAIN]   = p;
      values[REG_ENERGY_GAIN]  = e;
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_access(1'b1, 2'(i), values[i], back);
         gain_regs[i] = values[i];
      end
      for (int i = 0; i < 4; i++) begin
         csr_access(1'b0, 2'(i), '0, back);
         check_field("gain readback", gain_regs[i], back);
      end
   endtask

   task automatic run_directed_cases();
      frame_image_type f;
      frame_case_type  row;
      foreach (directed_cases[k]) begin
         row  = directed_cases[k];
         f[0] = row.hdr;
         for (int i = 1; i < FRAME_BYTES; i++) f[i] = row.fill;
         f[FRAME_BYTES-1] = frame_check_byte(f) ^ (row.bad_sum ? 8'hA5 : 8'h00);
         // Stray bytes outside a frame, then an abandoned partial frame
         repeat (row.strays) send_byte(8'($urandom), 1'b0, 1'b0, '0);
         for (int i = 0; i < row.partial; i++) send_byte(f[i], i == 0, 1'b0, '0);
         for (int i = 0; i < FRAME_BYTES; i++)
            send_byte(f[i], i == 0, row.typed && i == FRAME_BYTES - 1, row.want);
      end
   endtask

   task automatic send_random_frame();
      frame_image_type       f;
      logic [WORD_WIDTH-1:0] w;
      int                    kind;
      int                    n;
      gapless = ($urandom_range(0, 3) == 0);
      kind    = $urandom_range(0, 99);
      for (int i = 0; i < FRAME_BYTES; i++) f[i] = 8'($urandom);
      w = pick_word();
      {f[3], f[2], f[1]} = w;
      w = pick_word();
      {f[6], f[5], f[4]} = w;
      w = pick_word();
      {f[12], f[11], f[10]} = w;
      w = pick_word();
      {f[15], f[14], f[13]} = w;
      // Mostly well-formed; some bad header, bad checksum or both
      if ((kind >= 70 && kind < 80) || kind >= 90)
         f[0] = FRAME_HEADER ^ 8'($urandom_range(1, 255));
      else
         f[0] = FRAME_HEADER;
      f[FRAME_BYTES-1] = frame_check_byte(f);
      if (kind >= 80) f[FRAME_BYTES-1] = f[FRAME_BYTES-1] ^ 8'($urandom_range(1, 255));
      if ($urandom_range(0, 6) == 0)
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, 1'b0, '0);
      if ($urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, FRAME_BYTES - 1);
         for (int i = 0; i < n; i++) send_byte(8'($urandom), i == 0, 1'b0, '0);
      end
      for (int i = 0; i < FRAME_BYTES; i++) send_byte(f[i], i == 0, 1'b0, '0);
   endtask

   // Result side back-pressure: short and long stalls, some long free runs
   initial begin
      int hold;
      int run;
      @(posedge clock);
      forever begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8:      hold = 0;
            9, 10, 11, 12, 13, 14, 15, 16:  hold = $urandom_range(1, 4);
            default:                        hold = $urandom_range(10, 60);
         endcase
         run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat (run) @(posedge clock);
      end
   end

   // Check result beats and watch for a hang
   always @(posedge clock) begin
      reading_type seen;
      reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = '{rsp_error_code, rsp_raw_current, rsp_raw_voltage, rsp_raw_power,
                  rsp_pulse_count, rsp_status_byte, rsp_current_scaled,
                  rsp_voltage_scaled, rsp_power_scaled, rsp_energy_scaled};
         if (pending_readings.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result beat, error_code %0d", rsp_error_code);
         end else begin
            want = pending_readings.pop_front();
            compare_reading(want, seen);
         end
      end
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", pending_readings.size());
         $display("** energy_meter_frame_parser_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      reset_tracker();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      run_directed_cases();
      program_gains('1, '1, '1, '1);
      repeat (5) send_random_frame();
      program_gains('0, '0, '0, '0);
      repeat (5) send_random_frame();
      program_gains($urandom, $urandom, $urandom, $urandom);
      repeat (5) send_random_frame();
      program_gains(GAIN_ONE, 32'h0000_0001, 32'h8000_0000, $urandom_range(0, 32'h0400_0000));
      repeat (5) send_random_frame();
      // Drain and let late beats show up
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** energy_meter_frame_parser_unit: PASSED **");
      end else begin
         $display("** energy_meter_frame_parser_unit: FAILED **");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/emfp_pkg.sv
hw/rtl/emfp_front.sv
hw/rtl/emfp_queue.sv
hw/rtl/emfp_back.sv
hw/rtl/energy_meter_frame_parser_unit.sv
tb/sv/tb_energy_meter_frame_parser_unit.sv
